>>> sv/cbb_pkg.sv
// Shared types and constants of the circular byte buffer.
package cbb_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 9;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DROP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic exec_single;
    logic start_read;
    logic load_byte;
  } cbb_ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cmd_read;
    logic read_empty;
    logic out_free;
    logic more;
  } cbb_stat_t;

endpackage

>>> sv/cbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cbb_datapath.sv
// Datapath of the circular byte buffer: pointers, fill count, byte store, result register.
module cbb_datapath #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cbb_pkg::cbb_ctrl_t         ctrl_i,
  output cbb_pkg::cbb_stat_t         stat_o,
  input  logic [cbb_pkg::CMD_W-1:0]  command_i,
  input  logic [cbb_pkg::BYTE_W-1:0] write_byte_i,
  input  logic [cbb_pkg::CNT_W-1:0]  count_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [cbb_pkg::BYTE_W-1:0] read_byte_o,
  output logic                       byte_valid_o,
  output logic                       last_o,
  output logic [cbb_pkg::CNT_W-1:0]  done_count_o,
  output logic [cbb_pkg::CNT_W-1:0]  fill_level_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_READ + 1);
  localparam int unsigned WW = (FW > cbb_pkg::CNT_W) ? FW : cbb_pkg::CNT_W;
  localparam int unsigned SW = FW + 1;

  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [FW-1:0] DEPTH_F  = FW'(DEPTH);
  localparam logic [WW-1:0] MAXRD_W  = WW'(MAX_READ);

  logic [cbb_pkg::CMD_W-1:0]  cmd_q;
  logic [cbb_pkg::BYTE_W-1:0] wbyte_q;
  logic [cbb_pkg::CNT_W-1:0]  cnt_q;

  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] done_q, done_d;

  logic                       out_valid_q, out_valid_d;
  logic [cbb_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic                       out_bvalid_q, out_bvalid_d;
  logic                       out_last_q, out_last_d;
  logic [cbb_pkg::CNT_W-1:0]  out_done_q, out_done_d;
  logic [cbb_pkg::CNT_W-1:0]  out_fill_q, out_fill_d;

  logic [WW-1:0] cnt_w, fill_w, fill_d_w, rd_lim_w, rd_n_w, dr_n_w;
  logic [CW-1:0] rd_n;
  logic [FW-1:0] dr_n;
  logic [SW-1:0] dr_sum, dr_wrap;
  logic [PW-1:0] rd_ptr_inc, wr_ptr_inc;
  logic [CW-1:0] done_inc;
  logic          not_full, more, issue, load;
  logic          ram_we, ram_re;
  logic [cbb_pkg::BYTE_W-1:0] ram_rdata;

  // latch the accepted item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      cmd_q   <= command_i;
      wbyte_q <= write_byte_i;
      cnt_q   <= count_i;
    end
  end

  assign cnt_w    = WW'(cnt_q);
  assign fill_w   = WW'(fill_q);
  assign rd_lim_w = (cnt_w > MAXRD_W) ? MAXRD_W : cnt_w;
  assign rd_n_w   = (rd_lim_w > fill_w) ? fill_w : rd_lim_w;
  assign rd_n     = rd_n_w[CW-1:0];
  assign dr_n_w   = (cnt_w > fill_w) ? fill_w : cnt_w;
  assign dr_n     = dr_n_w[FW-1:0];
  assign dr_sum   = SW'(rd_ptr_q) + SW'(dr_n);
  assign dr_wrap  = (dr_sum >= DEPTH_S) ? dr_sum - DEPTH_S : dr_sum;

  assign rd_ptr_inc = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_inc = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
  assign not_full   = (fill_q != DEPTH_F);
  assign more       = (left_q != '0);
  assign done_inc   = done_q + 1'b1;
  assign issue      = ctrl_i.start_read | (ctrl_i.load_byte & more);
  assign load       = ctrl_i.exec_single | ctrl_i.load_byte;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    left_d   = left_q;
    done_d   = done_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;

    if (ctrl_i.exec_single) begin
      case (cmd_q)
        cbb_pkg::CMD_WRITE: begin
          if (not_full) begin
            ram_we   = 1'b1;
            wr_ptr_d = wr_ptr_inc;
            fill_d   = fill_q + 1'b1;
          end
        end
        cbb_pkg::CMD_DROP: begin
          fill_d   = fill_q - dr_n;
          rd_ptr_d = dr_wrap[PW-1:0];
          if (fill_d == '0) begin
            rd_ptr_d = '0;
            wr_ptr_d = '0;
          end
        end
        cbb_pkg::CMD_CLEAR: begin
          fill_d   = '0;
          rd_ptr_d = '0;
          wr_ptr_d = '0;
        end
        default: begin
          // read with nothing to deliver: state unchanged
        end
      endcase
    end

    if (ctrl_i.start_read) begin
      left_d = rd_n - 1'b1;
      done_d = '0;
    end
    if (ctrl_i.load_byte) begin
      done_d = done_inc;
      if (more) begin
        left_d = left_q - 1'b1;
      end
    end

    // fetch the next byte; return both pointers home when the buffer empties
    if (issue) begin
      ram_re   = 1'b1;
      rd_ptr_d = rd_ptr_inc;
      fill_d   = fill_q - 1'b1;
      if (fill_q == FW'(1)) begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
      end
    end
  end

  assign fill_d_w = WW'(fill_d);

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_bvalid_d = out_bvalid_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    out_fill_d   = out_fill_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.exec_single) begin
      out_byte_d   = '0;
      out_bvalid_d = 1'b0;
      out_last_d   = 1'b1;
      out_fill_d   = fill_d_w[cbb_pkg::CNT_W-1:0];
      case (cmd_q)
        cbb_pkg::CMD_WRITE: out_done_d = cbb_pkg::CNT_W'(not_full);
        cbb_pkg::CMD_DROP:  out_done_d = dr_n_w[cbb_pkg::CNT_W-1:0];
        default:            out_done_d = '0;
      endcase
    end
    if (ctrl_i.load_byte) begin
      out_byte_d   = ram_rdata;
      out_bvalid_d = 1'b1;
      out_last_d   = ~more;
      out_done_d   = cbb_pkg::CNT_W'(done_inc);
      out_fill_d   = fill_w[cbb_pkg::CNT_W-1:0];
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q       <= left_d;
    done_q       <= done_d;
    out_byte_q   <= out_byte_d;
    out_bvalid_q <= out_bvalid_d;
    out_last_q   <= out_last_d;
    out_done_q   <= out_done_d;
    out_fill_q   <= out_fill_d;
  end

  cbb_ram #(
    .WIDTH (cbb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (wbyte_q),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign stat_o.cmd_read   = (cmd_q == cbb_pkg::CMD_READ);
  assign stat_o.read_empty = (rd_n == '0);
  assign stat_o.out_free   = ~out_valid_q | out_ready_i;
  assign stat_o.more       = more;

  assign out_valid_o  = out_valid_q;
  assign read_byte_o  = out_byte_q;
  assign byte_valid_o = out_bvalid_q;
  assign last_o       = out_last_q;
  assign done_count_o = out_done_q;
  assign fill_level_o = out_fill_q;

endmodule

>>> sv/cbb_ctrl.sv
// Controller state machine of the circular byte buffer.
module cbb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cbb_pkg::cbb_stat_t stat_i,
  output cbb_pkg::cbb_ctrl_t ctrl_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d            = state_q;
    ctrl_o.load_item   = 1'b0;
    ctrl_o.exec_single = 1'b0;
    ctrl_o.start_read  = 1'b0;
    ctrl_o.load_byte   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_item = 1'b1;
          state_d          = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.cmd_read && !stat_i.read_empty) begin
          ctrl_o.start_read = 1'b1;
          state_d           = S_RDATA;
        end else if (stat_i.out_free) begin
          ctrl_o.exec_single = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_RDATA: begin
        // hand over one byte per free output slot, fetching the next alongside
        if (stat_i.out_free) begin
          ctrl_o.load_byte = 1'b1;
          if (!stat_i.more) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/circular_byte_buffer_top.sv
// Top level of the circular byte buffer.
// A byte ring buffer of DEPTH entries driven by one command per item: write one
// byte, read up to MAX_READ bytes (one result per byte, the final one flagged
// with last), drop bytes, or clear. An item is taken only while the block is
// idle. A write, drop, clear or empty read is executed in the EXEC state once
// the output register is free, which registers its single result on the
// output; the block then returns to idle for the next item. A read first
// latches the item, then issues the registered read of the byte store, then
// hands over one byte per cycle while the output is taken, limited by the
// single output register. The byte store needs no clearing pass after reset. A
// stalled output holds the block, though a read still fetches its first byte.
module circular_byte_buffer_top #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cbb_pkg::CMD_W-1:0]  command_i,
  input  logic [cbb_pkg::BYTE_W-1:0] write_byte_i,
  input  logic [cbb_pkg::CNT_W-1:0]  count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cbb_pkg::BYTE_W-1:0] read_byte_o,
  output logic                       byte_valid_o,
  output logic                       last_o,
  output logic [cbb_pkg::CNT_W-1:0]  done_count_o,
  output logic [cbb_pkg::CNT_W-1:0]  fill_level_o
);

  cbb_pkg::cbb_ctrl_t ctrl;
  cbb_pkg::cbb_stat_t stat;

  cbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cbb_datapath #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .command_i    (command_i),
    .write_byte_i (write_byte_i),
    .count_i      (count_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .read_byte_o  (read_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .done_count_o (done_count_o),
    .fill_level_o (fill_level_o)
  );

endmodule

>>> sv/cbb_checker.sv
// Port-level assertions of the circular byte buffer and their binding.
module cbb_port_checker #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [cbb_pkg::CMD_W-1:0]  command_i,
  input logic [cbb_pkg::BYTE_W-1:0] write_byte_i,
  input logic [cbb_pkg::CNT_W-1:0]  count_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [cbb_pkg::BYTE_W-1:0] read_byte_o,
  input logic                       byte_valid_o,
  input logic                       last_o,
  input logic [cbb_pkg::CNT_W-1:0]  done_count_o,
  input logic [cbb_pkg::CNT_W-1:0]  fill_level_o
);

  // a result held back by the sink stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o)
      && $stable(byte_valid_o) && $stable(last_o) && $stable(done_count_o)
      && $stable(fill_level_o))
    else $error("result changed while stalled");

  // one item at a time: no back-to-back acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in progress");

  // a delivered byte is counted and within the read limit
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> done_count_o != '0
      && done_count_o <= cbb_pkg::CNT_W'(MAX_READ))
    else $error("delivered byte with bad count");

  // a result without a byte closes its item and carries a zero byte
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o && read_byte_o == '0)
    else $error("byteless result not final or not zero");

  // fill level never exceeds the capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> DEPTH > 511 || fill_level_o <= cbb_pkg::CNT_W'(DEPTH))
    else $error("fill level above capacity");

endmodule

bind circular_byte_buffer_top cbb_port_checker #(
  .DEPTH    (DEPTH),
  .MAX_READ (MAX_READ)
) u_cbb_checker (.*);
